// ----- design/srwg_pkg.sv -----
// Package: shared types, constants and functions for the smoothed random wave generator.
`timescale 1ns / 1ps
package srwg_pkg;

  localparam logic [31:0] LfsrMask    = 32'h8020_0003;
  localparam logic [24:0] OneQ24      = 25'h100_0000;
  localparam logic [23:0] NyqReset    = 24'd6144000;
  localparam logic [31:0] InvNyqReset = 32'd178957;
  localparam logic [31:0] SeedReset   = 32'd1;

  localparam logic [1:0] RegNyquist = 2'd0;
  localparam logic [1:0] RegInvNyq  = 2'd1;
  localparam logic [1:0] RegSeed    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_CLIP,
    ST_DIV,
    ST_ROM,
    ST_INTERP,
    ST_MIX,
    ST_INC,
    ST_WRAP,
    ST_DRAW,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_seed;
    logic clip;
    logic div_start;
    logic div_step;
    logic rom_read;
    logic interp;
    logic mix;
    logic inc;
    logic wrap;
    logic draw_step;
    logic draw_commit;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic div_needed;
    logic div_done;
    logic wrapped;
    logic draw_done;
    logic seed_second;
  } stat_t;

  // One Galois step to the right.
  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    lfsr_step = s[0] ? ((s >> 1) ^ LfsrMask) : (s >> 1);
  endfunction

  // Cosine table value for k in 0..2^bits, Q1.15, built by 24-step CORDIC.
  function automatic logic signed [17:0] cos_entry(input int k, input int bits);
    longint atan_t [24];
    longint x, y, z, dx, dy, c, th;
    int n, u, i;
    atan_t = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
               16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
               131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
               128};
    n = 1 << bits;
    u = (k <= n / 2) ? k : n - k;
    th = (64'd3373259426 * longint'(u)) >>> bits;
    x = 652032875;
    y = 0;
    z = th;
    for (i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_t[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_t[i];
      end
    end
    c = (x + 16384) >>> 15;
    if (k > n / 2) c = -c;
    if (c > 32768) c = 32768;
    if (c < -32768) c = -32768;
    cos_entry = 18'(c);
  endfunction

endpackage

// ----- design/srwg_ctrl.sv -----
// Controller: sequences one sample request through the shared datapath.
`timescale 1ns / 1ps
module srwg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_valid_i,
  input  logic           seed_req_i,
  input  srwg_pkg::stat_t stat_i,
  output srwg_pkg::ctrl_t ctrl_o
);
  import srwg_pkg::*;

  state_e state_q, state_d;
  logic   seed_q, seed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SEED;
      seed_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    seed_d     = seed_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_i && !seed_req_i;
        if (seed_req_i) begin
          ctrl_o.load_seed = 1'b1;
          seed_d  = 1'b0;
          state_d = ST_DRAW;
        end else if (in_valid_i && !out_valid_i) begin
          ctrl_o.clip = 1'b1;
          state_d = ST_CLIP;
        end
      end
      ST_SEED: begin
        ctrl_o.load_seed = 1'b1;
        seed_d  = 1'b0;
        state_d = ST_DRAW;
      end
      ST_CLIP: begin
        ctrl_o.div_start = 1'b1;
        state_d = stat_i.div_needed ? ST_DIV : ST_MIX;
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = ST_ROM;
      end
      ST_ROM: begin
        ctrl_o.rom_read = 1'b1;
        state_d = ST_INTERP;
      end
      ST_INTERP: begin
        ctrl_o.interp = 1'b1;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        ctrl_o.mix = 1'b1;
        state_d = ST_INC;
      end
      ST_INC: begin
        ctrl_o.inc = 1'b1;
        state_d = ST_WRAP;
      end
      ST_WRAP: begin
        ctrl_o.wrap = 1'b1;
        ctrl_o.out_load = 1'b1;
        seed_d  = 1'b1;
        state_d = stat_i.wrapped ? ST_DRAW : ST_IDLE;
      end
      ST_DRAW: begin
        ctrl_o.draw_step = 1'b1;
        if (stat_i.draw_done) begin
          ctrl_o.draw_commit = 1'b1;
          // After a seed load, a second draw follows; after a wrap, one draw.
          if (!seed_q && !stat_i.seed_second) state_d = ST_DRAW;
          else state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- design/srwg_dp.sv -----
// Datapath: phase, levels, LFSR, serial divider, cosine table and mix.
`timescale 1ns / 1ps
module srwg_dp #(
  parameter int COS_TABLE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [23:0]         frequency_i,
  input  logic [16:0]         smoothness_i,
  input  logic [23:0]         nyq_i,
  input  logic [31:0]         inv_nyq_i,
  input  logic [31:0]         seed_i,
  input  srwg_pkg::ctrl_t     ctrl_i,
  output srwg_pkg::stat_t     stat_o,
  output logic signed [15:0]  sample_o
);
  import srwg_pkg::*;

  localparam int N  = 1 << COS_TABLE_BITS;
  localparam int FB = 24 - COS_TABLE_BITS;

  logic signed [17:0] rom [N+1];
  for (genvar k = 0; k <= N; k++) begin : g_rom
    assign rom[k] = cos_entry(k, COS_TABLE_BITS);
  end

  logic [24:0] phase_q;
  logic [31:0] lfsr_q;
  logic signed [15:0] prev_q, next_q;
  logic [23:0] f_q;
  logic [16:0] s_q;
  logic signed [17:0] shape_q;
  logic [40:0] rem_q;
  logic [40:0] quo_q;
  logic [5:0]  cnt_q;
  logic [4:0]  dcnt_q;
  logic        second_q;
  logic signed [17:0] a_q, b_q;
  logic [FB-1:0] frac_q;
  logic [55:0] prod_q;
  logic signed [15:0] out_q;

  logic [23:0] interval;
  logic [24:0] diff;
  logic        region_hi, region_lo;
  assign interval  = {(17'h10000 - s_q), 7'd0};
  assign region_hi = phase_q < {1'b0, interval};
  assign region_lo = phase_q > (OneQ24 - {1'b0, interval});
  assign diff      = phase_q - {1'b0, interval};

  logic [24:0] xq;
  assign xq = (quo_q > 41'(OneQ24)) ? OneQ24 : quo_q[24:0];
  logic [COS_TABLE_BITS:0] idx;
  assign idx = xq[24:FB];

  logic signed [17:0] dd;
  logic signed [18+FB:0] dprod;
  assign dd    = b_q - a_q;
  assign dprod = dd * $signed({1'b0, frac_q});

  logic signed [33:0] mixn;
  logic signed [17:0] mixr;
  assign mixn = shape_q * (34'(next_q) - 34'(prev_q))
              - ((34'(next_q) + 34'(prev_q)) <<< 15) + 34'sd32768;
  assign mixr = 18'(mixn >>> 16);

  logic [41:0] rem_sh;
  assign rem_sh = {rem_q, quo_q[40]};

  logic [24:0] phase_n;
  logic [23:0] inc;
  assign inc     = (prod_q[55:16] > 40'hFF_FFFF) ? 24'hFF_FFFF : prod_q[39:16];
  assign phase_n = phase_q + {1'b0, inc};

  assign stat_o.div_needed  = !region_hi && !region_lo;
  assign stat_o.div_done    = cnt_q == 6'd41;
  assign stat_o.wrapped     = phase_n > OneQ24;
  assign stat_o.draw_done   = dcnt_q == 5'd15;
  assign stat_o.seed_second = second_q;
  assign sample_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      cnt_q    <= '0;
      dcnt_q   <= '0;
      second_q <= 1'b0;
    end else begin
      if (ctrl_i.div_start) cnt_q <= '0;
      else if (ctrl_i.div_step) cnt_q <= cnt_q + 6'd1;
      if (ctrl_i.load_seed) begin
        dcnt_q <= '0;
        second_q <= 1'b0;
      end else if (ctrl_i.draw_step) begin
        // Restart the step count so each draw is exactly 16 steps.
        dcnt_q <= ctrl_i.draw_commit ? 5'd0 : dcnt_q + 5'd1;
        if (ctrl_i.draw_commit) second_q <= !second_q;
      end
      if (ctrl_i.wrap) phase_q <= stat_o.wrapped ? phase_n - OneQ24 : phase_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_seed) lfsr_q <= (seed_i == '0) ? 32'd1 : seed_i;
    else if (ctrl_i.draw_step) lfsr_q <= lfsr_step(lfsr_q);
    // Shift the levels: the older one moves down, the fresh draw comes in on top.
    if (ctrl_i.draw_commit) begin
      prev_q <= next_q;
      next_q <= $signed(lfsr_step(lfsr_q)[15:0]);
    end
    if (ctrl_i.clip) begin
      f_q <= (frequency_i > nyq_i) ? nyq_i : frequency_i;
      s_q <= (smoothness_i > 17'h10000) ? 17'h10000 : smoothness_i;
    end
    if (ctrl_i.div_start) begin
      rem_q <= '0;
      quo_q <= (s_q == '0) ? 41'd0 : {diff[24:0], 16'd0};
      shape_q <= region_hi ? 18'sd32768 : -18'sd32768;
    end else if (ctrl_i.div_step && !stat_o.div_done) begin
      if (s_q != '0 && rem_sh >= 42'(s_q)) begin
        rem_q <= 41'(rem_sh - 42'(s_q));
        quo_q <= {quo_q[39:0], 1'b1};
      end else begin
        rem_q <= rem_sh[40:0];
        quo_q <= {quo_q[39:0], 1'b0};
      end
    end
    if (ctrl_i.rom_read) begin
      if (idx >= (COS_TABLE_BITS+1)'(N)) begin
        a_q <= rom[N];
        b_q <= rom[N];
      end else begin
        a_q <= rom[idx];
        b_q <= rom[idx + 1'b1];
      end
      frac_q <= xq[FB-1:0];
    end
    if (ctrl_i.interp) shape_q <= a_q + 18'(dprod >>> FB);
    if (ctrl_i.mix) begin
      out_q <= (mixr > 18'sd32767) ? 16'sh7FFF :
               (mixr < -18'sd32768) ? 16'sh8000 : mixr[15:0];
      prod_q <= 56'(f_q) * 56'(inv_nyq_i);
    end
  end

endmodule

// ----- design/smoothed_random_wave_generator_unit.sv -----
// Top level: smoothed random wave generator with request handshakes and register port.
`timescale 1ns / 1ps
// Each request carries a frequency and a smoothness and yields one signed Q1.15 sample,
// a cosine glide between two random levels drawn from a seeded 32-bit LFSR. On a flat
// region the sample skips the divider; on the cosine ramp it waits for the 41-step
// restoring divider that scales the phase by 1/smoothness, then the cosine table
// read and interpolation. A phase wrap then adds LFSR stepping before the next request
// can be taken. After reset, and after each random_seed write, the block draws both
// levels before it accepts a request. The result waits in an output register; the next
// request is taken from the cycle after it is delivered.
module smoothed_random_wave_generator_unit #(
  parameter int COS_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [23:0]        frequency_i,
  input  logic [16:0]        smoothness_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import srwg_pkg::*;

  logic [23:0] nyq_q;
  logic [31:0] inv_q, seed_q;
  logic        seed_req_q, ov_q;
  ctrl_t       ctrl;
  stat_t       stat;

  // Config writes always land; a seed write raises a reseed request.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nyq_q      <= NyqReset;
      inv_q      <= InvNyqReset;
      seed_q     <= SeedReset;
      seed_req_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      // A fresh seed write wins over the clear of an older request.
      if (cfg_valid_i && cfg_index_i == RegSeed) seed_req_q <= 1'b1;
      else if (ctrl.load_seed) seed_req_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegNyquist: nyq_q <= cfg_data_i[23:0];
          RegInvNyq:  inv_q <= cfg_data_i;
          RegSeed:    seed_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Hold the sample until taken.
      if (ctrl.out_load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;

  srwg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_valid_i(ov_q), .seed_req_i(seed_req_q),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  srwg_dp #(.COS_TABLE_BITS(COS_TABLE_BITS)) u_dp (
    .clk_i, .rst_ni, .frequency_i, .smoothness_i,
    .nyq_i(nyq_q), .inv_nyq_i(inv_q), .seed_i(seed_q),
    .ctrl_i(ctrl), .stat_o(stat), .sample_o
  );

endmodule

// ----- design/srwg_checker.sv -----
// Checker: port-level properties of the wave generator, bound to the top level.
`timescale 1ns / 1ps
module srwg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] sample_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o))
    else $error("sample dropped while stalled");
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("request taken with result pending");
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result appeared too soon");
endmodule

bind smoothed_random_wave_generator_unit srwg_checker u_chk (.*);
